[rtl/pdit_pkg.sv]
// Shared types and constants for the pulse-distance IR transmitter.
package pdit_pkg;

    localparam int unsigned TICK_W      = 16;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input kind codes
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_ZERO_GAP = 2'd0;
    localparam logic [1:0] REG_ONE_GAP  = 2'd1;
    localparam logic [1:0] REG_END_GAP  = 2'd2;
    localparam logic [1:0] REG_PULSE    = 2'd3;

    localparam logic [TICK_W-1:0] ZERO_GAP_RST = 16'd100;
    localparam logic [TICK_W-1:0] ONE_GAP_RST  = 16'd200;
    localparam logic [TICK_W-1:0] END_GAP_RST  = 16'd400;
    localparam logic [TICK_W-1:0] PULSE_RST    = 16'd20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic led_out;
        logic busy_res;
        logic rejected;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SEND,
        OP_END,
        OP_NOP
    } op_t;

    // Classified command, byte already normalized to MSB-aligned
    typedef struct packed {
        op_t        op;
        logic [7:0] shift_bits;
        logic [3:0] bits_left;
    } cmd_t;

    typedef struct packed {
        logic [TICK_W-1:0] zero_gap_ticks;
        logic [TICK_W-1:0] one_gap_ticks;
        logic [TICK_W-1:0] end_gap_ticks;
        logic [TICK_W-1:0] pulse_ticks;
    } cfg_t;

endpackage

[rtl/pdit_front.sv]
// Front end: decodes the input kind and strips leading zeros from a data byte.
module pdit_front
    import pdit_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic [2:0] msb_pos;
    logic       any_one;

    // highest set bit of the byte
    always_comb
    begin
        msb_pos = 3'd0;
        any_one = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (in_data.data_byte[i])
            begin
                msb_pos = 3'(i);
                any_one = 1'b1;
            end
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_cmd.shift_bits = 8'd0;
        push_cmd.bits_left  = 4'd0;
        case (in_data.kind)
            KIND_TICK: push_cmd.op = OP_TICK;
            KIND_SEND:
            begin
                push_cmd.op = OP_SEND;
                if (any_one)
                begin
                    push_cmd.shift_bits = in_data.data_byte << (3'd7 - msb_pos);
                    push_cmd.bits_left  = {1'b0, msb_pos} + 4'd1;
                end
                else
                begin
                    push_cmd.bits_left = 4'd1;   // zero byte sends one 0 bit
                end
            end
            KIND_END:  push_cmd.op = OP_END;
            default:   push_cmd.op = OP_NOP;
        endcase
    end

endmodule

[rtl/pdit_queue.sv]
// Two-entry command queue between front end and back end.
module pdit_queue
    import pdit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
`endif

endmodule

[rtl/pdit_back.sv]
// Back end: gap/pulse sequencer and registered result beat.
module pdit_back
    import pdit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GAP,
        PH_PULSE,
        PH_SPARE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        shift_reg, shift_next;
    logic [3:0]        bits_left_reg, bits_left_next;
    logic [TICK_W-1:0] timer_reg, timer_next;
    logic              end_reg, end_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;
    logic              busy;
    logic              rej;
    logic              expired;

    assign pop     = q_valid && (!out_valid_reg || out_ready);
    assign busy    = (phase_reg == PH_GAP) || (phase_reg == PH_PULSE);
    assign expired = (timer_reg <= TICK_W'(1));

    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        timer_next     = timer_reg;
        end_next       = end_reg;
        rej            = 1'b0;

        if (pop)
        begin
            case (q_cmd.op)
                OP_TICK:
                begin
                    if (busy)
                    begin
                        timer_next = expired ? '0 : timer_reg - 1'b1;
                        if (expired)
                        begin
                            if (phase_reg == PH_GAP)
                            begin
                                phase_next = PH_PULSE;
                                timer_next = cfg.pulse_ticks;
                                if (!end_reg)
                                begin
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    if (bits_left_reg != '0)
                                        bits_left_next = bits_left_reg - 1'b1;
                                end
                            end
                            else if (!end_reg && bits_left_reg != '0)
                            begin
                                phase_next = PH_GAP;
                                timer_next = shift_reg[7] ? cfg.one_gap_ticks
                                                          : cfg.zero_gap_ticks;
                            end
                            else
                            begin
                                phase_next     = PH_IDLE;
                                timer_next     = '0;
                                end_next       = 1'b0;
                                bits_left_next = '0;
                                shift_next     = '0;
                            end
                        end
                    end
                end
                OP_SEND:
                begin
                    if (busy)
                        rej = 1'b1;
                    else
                    begin
                        shift_next     = q_cmd.shift_bits;
                        bits_left_next = q_cmd.bits_left;
                        end_next       = 1'b0;
                        phase_next     = PH_GAP;
                        timer_next     = q_cmd.shift_bits[7] ? cfg.one_gap_ticks
                                                             : cfg.zero_gap_ticks;
                    end
                end
                OP_END:
                begin
                    if (busy)
                        rej = 1'b1;
                    else
                    begin
                        shift_next     = '0;
                        bits_left_next = '0;
                        end_next       = 1'b1;
                        phase_next     = PH_GAP;
                        timer_next     = cfg.end_gap_ticks;
                    end
                end
                default: ;
            endcase
        end

        out_data_next.led_out  = (phase_next == PH_PULSE);
        out_data_next.busy_res = (phase_next == PH_GAP) || (phase_next == PH_PULSE);
        out_data_next.rejected = rej;

        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            timer_reg     <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            timer_reg     <= timer_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
            if (pop)
                out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_led_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.led_out |-> out_data_reg.busy_res)
        else $error("LED lit while not busy");

    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.rejected |-> out_data_reg.busy_res)
        else $error("reject reported while idle");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> timer_reg == '0 && bits_left_reg == '0 && !end_reg)
        else $error("idle with leftover transfer state");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= 4'd8)
        else $error("bit count out of range");
`endif

endmodule

[rtl/pulse_distance_ir_transmitter.sv]
// Top level of the pulse-distance IR transmitter: config registers and wiring.
//
// Pulse-distance IR transmitter. Each input beat is either a tick (one unit of
// time passes), a send-byte command or an end-marker command; every input beat
// produces exactly one result beat carrying the LED level, the busy flag and a
// reject flag for commands that arrive mid-transfer. A byte is sent MSB first
// starting at its highest 1 bit (a zero byte sends a single 0 bit); each bit is
// a gap of zero_gap_ticks or one_gap_ticks followed by pulse_ticks of LED on.
// The end marker is a gap of end_gap_ticks followed by one pulse. The block
// takes one beat per clock sustained while out_ready stays high; a result
// passes the command queue, then the output register. The rate is set by
// the back-end sequencer, which retires one command per cycle unless stalled.
// Gap and pulse lengths are sampled when a gap or pulse starts, so registers
// should be written only while the transmitter is idle. A length of zero acts
// as one tick.
module pulse_distance_ir_transmitter
    import pdit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input beats
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    // result beats
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    // configuration writes
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [TICK_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic q_valid;
    cmd_t q_cmd;
    logic pop;

    // timing registers, written with no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_gap_ticks <= ZERO_GAP_RST;
            cfg_reg.one_gap_ticks  <= ONE_GAP_RST;
            cfg_reg.end_gap_ticks  <= END_GAP_RST;
            cfg_reg.pulse_ticks    <= PULSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_GAP: cfg_reg.zero_gap_ticks <= cfg_data;
                REG_ONE_GAP:  cfg_reg.one_gap_ticks  <= cfg_data;
                REG_END_GAP:  cfg_reg.end_gap_ticks  <= cfg_data;
                REG_PULSE:    cfg_reg.pulse_ticks    <= cfg_data;
                default: ;
            endcase
        end
    end

    // front end: decode and normalize, no state
    pdit_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples front and back so each side stalls on its own
    pdit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    // back end: gap/pulse sequencer plus output register
    pdit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[tb/sv/tb_pulse_distance_ir_transmitter.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the pulse-distance IR transmitter: stimulus, predictor, scoreboard.
module tb_pulse_distance_ir_transmitter;
    import pdit_pkg::*;

    localparam int CLK_HALF    = 4;          // 8 ns period
    localparam int RST_CYCLES  = 7;
    localparam int CYCLE_LIMIT = 200_000;    // watchdog limit for the whole run
    localparam int MAX_WAIT    = 16;         // per-beat idle draw, both sides
    localparam int HOLD_CYCLES = 300;        // one long receiver hold-off
    localparam int RAND_PHASES = 6;
    localparam int PHASE_BEATS = 50;
    localparam int TICK_TOP    = 65535;
    localparam int MAX_REPORTS = 10;

    // Code 3 is unused by the block; it must behave as a no-op.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_GAP,
        TX_PULSE
    } tx_phase_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup. Every input has a known value at t=0.
    // ------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [TICK_W-1:0] cfg_data  = '0;

    always #(CLK_HALF) clk = ~clk;

    pulse_distance_ir_transmitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bookkeeping shared between stimulus, driver and monitor.
    // ------------------------------------------------------------------
    in_item_t    pend_q[$];        // beats waiting to be offered
    out_item_t   line_state_q[$];  // predicted LED/busy/reject per accepted beat
    logic        idle_en   = 1'b1; // random idling on both sides
    logic        hold_go   = 1'b0; // arms the one long receiver hold-off
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int          n_err = 0;
    int          n_in  = 0;
    int          n_out = 0;
    int          n_cmd = 0;
    int          n_rej = 0;
    int          n_wr  = 0;
    int          cycle_cnt = 0;

    // ------------------------------------------------------------------
    // Transmitter predictor: register mirror plus its own copy of the
    // shift/timer state, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    cfg_t              reg_mirror;
    logic [7:0]        tx_shift;   // next bit to send sits in bit 7
    logic [3:0]        tx_left;    // bits whose gap has not yet ended
    tx_phase_t         tx_phase;
    logic [TICK_W-1:0] tx_timer;
    logic              tx_end;     // running transfer is the end marker

    function automatic logic [TICK_W-1:0] next_gap_len();
        if (tx_end)
            return reg_mirror.end_gap_ticks;
        return tx_shift[7] ? reg_mirror.one_gap_ticks : reg_mirror.zero_gap_ticks;
    endfunction

    // Strip leading zeros; a zero byte still sends one 0 bit.
    function automatic void msb_align(input logic [7:0] b, output logic [7:0] s,
                                      output logic [3:0] n);
        s = b;
        n = 4'd8;
        if (b == 8'h00)
            n = 4'd1;
        else
            while (!s[7])
            begin
                s = s << 1;
                n = n - 4'd1;
            end
    endfunction

    // One tick while busy. A loaded length of 0 or 1 expires on this tick.
    function automatic void tick_once();
        logic expired;
        expired  = (tx_timer <= 1);
        tx_timer = expired ? '0 : tx_timer - 1'b1;
        if (expired)
        begin
            if (tx_phase == TX_GAP)
            begin
                tx_phase = TX_PULSE;
                tx_timer = reg_mirror.pulse_ticks;
                if (!tx_end)
                begin
                    tx_shift = tx_shift << 1;
                    if (tx_left != 0)
                        tx_left = tx_left - 4'd1;
                end
            end
            else if (!tx_end && tx_left != 0)
            begin
                tx_phase = TX_GAP;
                tx_timer = next_gap_len();
            end
            else
            begin
                tx_phase = TX_IDLE;
                tx_timer = '0;
                tx_end   = 1'b0;
                tx_left  = '0;
                tx_shift = '0;
            end
        end
    endfunction

    function automatic out_item_t tx_predict(input in_item_t beat);
        out_item_t r;
        logic      busy;
        r    = '0;
        busy = (tx_phase != TX_IDLE);
        case (beat.kind)
            KIND_TICK:
                if (busy)
                    tick_once();
            KIND_SEND, KIND_END:
                if (busy)
                    r.rejected = 1'b1;   // refused, no tick passes
                else
                begin
                    if (beat.kind == KIND_SEND)
                    begin
                        msb_align(beat.data_byte, tx_shift, tx_left);
                        tx_end = 1'b0;
                    end
                    else
                    begin
                        tx_shift = '0;
                        tx_left  = '0;
                        tx_end   = 1'b1;
                    end
                    // first gap counts from the next tick beat
                    tx_phase = TX_GAP;
                    tx_timer = next_gap_len();
                end
            default: ;  // spare code: nothing happens
        endcase
        r.led_out  = (tx_phase == TX_PULSE);
        r.busy_res = (tx_phase != TX_IDLE);
        return r;
    endfunction

    // Ticks needed to run a burst to idle with the current registers
    // (upper bound: every bit charged the longer gap).
    function automatic int burst_ticks(input logic [1:0] k, input logic [7:0] b);
        logic [7:0] s;
        logic [3:0] n;
        int         gap_top;
        if (k == KIND_END)
            return int'(reg_mirror.end_gap_ticks) + int'(reg_mirror.pulse_ticks);
        msb_align(b, s, n);
        gap_top = (reg_mirror.one_gap_ticks > reg_mirror.zero_gap_ticks) ?
                  int'(reg_mirror.one_gap_ticks) : int'(reg_mirror.zero_gap_ticks);
        return int'(n) * (gap_top + int'(reg_mirror.pulse_ticks));
    endfunction

    // ------------------------------------------------------------------
    // Input driver. Holds a beat until taken; after each accepted beat it
    // draws an idle gap before offering the next one. The prediction is
    // made at the accepting edge from the payload that was on the bus.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned gap;
        out_item_t   pred;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            send_wait <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                pred = tx_predict(in_data);
                line_state_q.push_back(pred);
                n_in++;
                if (pred.rejected)
                    n_rej++;
                else if (in_data.kind == KIND_SEND || in_data.kind == KIND_END)
                    n_cmd++;
                gap = idle_en ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else
                gap = send_wait;

            if (gap == 0 && pend_q.size() != 0)
            begin
                in_data   <= pend_q.pop_front();
                in_valid  <= 1'b1;
                send_wait <= 0;
            end
            else
            begin
                in_valid  <= 1'b0;
                send_wait <= (gap != 0) ? gap - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver hold-off: one long stretch with ready low while the driver
    // keeps offering, so the internal command queue fills and in_ready drops.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Result monitor and scoreboard. Each taken result beat is checked
    // field by field against the oldest prediction, then a fresh random
    // wait is drawn before ready is next held high.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned w;
        out_item_t   want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_out++;
                if (line_state_q.size() == 0)
                begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("[%0t] result beat %0d with nothing predicted: %s%b %s%b %s%b",
                                 $realtime, n_out, "led=", out_data.led_out,
                                 "busy=", out_data.busy_res, "rej=", out_data.rejected);
                end
                else
                begin
                    want = line_state_q.pop_front();
                    if (out_data.led_out !== want.led_out ||
                        out_data.busy_res !== want.busy_res ||
                        out_data.rejected !== want.rejected)
                    begin
                        n_err++;
                        if (n_err <= MAX_REPORTS)
                            $display({"[%0t] result beat %0d: expected led=%b busy=%b rej=%b,",
                                      " got led=%b busy=%b rej=%b"},
                                     $realtime, n_out,
                                     want.led_out, want.busy_res, want.rejected,
                                     out_data.led_out, out_data.busy_res, out_data.rejected);
                    end
                end
                w = idle_en ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else
                w = recv_wait;

            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= w;
            end
            else if (w != 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= w - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("pulse_distance_ir_transmitter regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    // Register write; the mirror follows right away since nothing is in
    // flight when this is called.
    task automatic write_reg(input logic [1:0] idx, input logic [TICK_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ZERO_GAP: reg_mirror.zero_gap_ticks = val;
            REG_ONE_GAP:  reg_mirror.one_gap_ticks  = val;
            REG_END_GAP:  reg_mirror.end_gap_ticks  = val;
            REG_PULSE:    reg_mirror.pulse_ticks    = val;
            default: ;
        endcase
        n_wr++;
    endtask

    task automatic set_regs(input int zg, input int og, input int eg, input int pt);
        write_reg(REG_ZERO_GAP, TICK_W'(zg));
        write_reg(REG_ONE_GAP,  TICK_W'(og));
        write_reg(REG_END_GAP,  TICK_W'(eg));
        write_reg(REG_PULSE,    TICK_W'(pt));
    endtask

    function automatic void push_beat(input logic [1:0] k, input logic [7:0] b);
        in_item_t it;
        it.kind      = k;
        it.data_byte = b;
        pend_q.push_back(it);
    endfunction

    // Tick beats carry a random don't-care byte.
    function automatic void push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_beat(KIND_TICK, 8'($urandom));
    endfunction

    // Back at a falling edge once every beat is taken and every result seen.
    task automatic wait_tx_drained();
        @(negedge clk);
        while (pend_q.size() != 0 || in_valid || line_state_q.size() != 0)
            @(negedge clk);
    endtask

    // Mostly complete bursts (command, then enough ticks to reach idle),
    // with stray commands dropped in mid-burst and some bursts cut short.
    // The phase stops at its beat budget, possibly in the middle of a burst.
    function automatic void fill_random_phase(input int beats);
        int         pushed;
        int         roll;
        int         ticks;
        logic [7:0] b;
        logic [1:0] k;
        pushed = 0;
        while (pushed < beats)
        begin
            roll = $urandom_range(0, 99);
            // vary the leading-zero count
            b = 8'($urandom_range(0, 255)) >> $urandom_range(0, 7);
            if (roll < 70)
                k = KIND_SEND;
            else if (roll < 85)
                k = KIND_END;
            else if (roll < 93)
                k = KIND_TICK;
            else
                k = KIND_SPARE;
            push_beat(k, b);
            pushed++;
            if (k == KIND_SEND || k == KIND_END)
            begin
                ticks = burst_ticks(k, b);
                if ($urandom_range(0, 7) == 0)
                    ticks = $urandom_range(0, ticks);   // next command lands mid-burst
                else
                    ticks += $urandom_range(0, 3);
                for (int i = 0; i < ticks && pushed < beats; i++)
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        push_beat(2'($urandom_range(1, 3)), 8'($urandom));
                        pushed++;
                    end
                    push_beat(KIND_TICK, 8'($urandom));
                    pushed++;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int top;
        reg_mirror = '{zero_gap_ticks: ZERO_GAP_RST, one_gap_ticks: ONE_GAP_RST,
                       end_gap_ticks: END_GAP_RST, pulse_ticks: PULSE_RST};
        tx_shift = '0;
        tx_left  = '0;
        tx_phase = TX_IDLE;
        tx_timer = '0;
        tx_end   = 1'b0;

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: short lengths so every burst finishes quickly.
        set_regs(1, 2, 3, 1);
        push_beat(KIND_TICK, 8'hFF);    // tick while idle does nothing
        push_beat(KIND_SPARE, 8'hFF);   // spare code while idle
        push_beat(KIND_SEND, 8'h00);    // zero byte sends a single 0 bit
        push_beat(KIND_SEND, 8'h5A);    // refused while busy
        push_beat(KIND_END, 8'h00);     // refused while busy
        push_beat(KIND_SPARE, 8'h00);   // spare code mid-burst, no tick
        push_ticks(3);
        push_beat(KIND_SEND, 8'hFF);    // all eight bits, one gaps
        push_ticks(24);
        push_beat(KIND_SEND, 8'h01);    // seven leading zeros skipped
        push_ticks(4);
        push_beat(KIND_END, 8'hA5);     // end marker, byte ignored
        push_ticks(5);
        wait_tx_drained();

        // Zero-length registers behave as one tick.
        set_regs(0, 0, 0, 0);
        push_beat(KIND_SEND, 8'h80);
        push_ticks(17);
        push_beat(KIND_END, 8'h00);
        push_ticks(3);
        wait_tx_drained();

        // Random phases: all-ones lengths first, one phase without idling,
        // one with longer lengths, and the long hold-off in phase one.
        // A phase may end mid-burst, so the next register set lands mid-transfer.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_en = (ph != 2);
            top     = (ph == 0) ? 1 : ((ph == 4) ? 12 : 5);
            set_regs($urandom_range(1, top), $urandom_range(1, top),
                     $urandom_range(1, top), $urandom_range(1, top));
            fill_random_phase(PHASE_BEATS);
            if (ph == 1)
                hold_go <= 1'b1;
            wait_tx_drained();
        end

        // Run the last burst out so the full-scale load starts from idle.
        while (tx_phase != TX_IDLE)
        begin
            push_ticks(4);
            wait_tx_drained();
        end

        // Full-scale lengths: load and count down from the top of the range;
        // the run ends with that gap still open.
        idle_en = 1'b0;
        set_regs(TICK_TOP, TICK_TOP, TICK_TOP, TICK_TOP);
        push_beat(KIND_SEND, 8'h80);
        push_ticks(20);
        push_beat(KIND_END, 8'h00);     // refused while busy
        push_ticks(10);
        wait_tx_drained();

        // let any stray result beat show up before the verdict
        repeat (8) @(posedge clk);

        $display("covered %0d input beats, %0d result beats, %0d bursts started, %0d refused",
                 n_in, n_out, n_cmd, n_rej);
        $display("covered %0d register writes incl. zero and full-scale lengths, %0d mismatches",
                 n_wr, n_err);
        if (n_err == 0 && line_state_q.size() == 0)
            $display("pulse_distance_ir_transmitter regression: pass");
        else
            $display("pulse_distance_ir_transmitter regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/pdit_pkg.sv
rtl/pdit_front.sv
rtl/pdit_queue.sv
rtl/pdit_back.sv
rtl/pulse_distance_ir_transmitter.sv
tb/sv/tb_pulse_distance_ir_transmitter.sv
